// ===== sv/pfa_pkg.sv =====
package pfa_pkg;

  // Default prime: largest below 2^16
  localparam int unsigned MODULUS_DEFAULT = 65521;

  // Field element width
  localparam int unsigned ELEM_W = 16;

  // Inverse table depth (one entry per 16-bit address)
  localparam int unsigned ROM_DEPTH = 65536;

  // Register stages inside pfa_mulmod
  localparam int unsigned MUL_LAT = 4;

  // Output queue depth, also the most words that can be in flight
  localparam int unsigned FIFO_DEPTH = 8;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INV = 3'd5
  } opcode_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [ELEM_W-1:0] operand_a;
    logic [ELEM_W-1:0] operand_b;
  } pfa_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] result;
    logic              zero_divide;
  } pfa_out_t;

  typedef enum logic [1:0] {
    FILL_INIT,
    FILL_FWD,
    FILL_BWD,
    FILL_DONE
  } fill_state_t;

endpackage

// ===== sv/pfa_mulmod.sv =====
// x*y mod MODULUS, Barrett reduction, MUL_LAT register stages
module pfa_mulmod #(
  parameter int unsigned MODULUS = pfa_pkg::MODULUS_DEFAULT
) (
  input  logic                        clk,
  input  logic [pfa_pkg::ELEM_W-1:0]  x,
  input  logic [pfa_pkg::ELEM_W-1:0]  y,
  output logic [pfa_pkg::ELEM_W-1:0]  res
);

  localparam logic [pfa_pkg::ELEM_W-1:0] Mod = MODULUS[pfa_pkg::ELEM_W-1:0];
  // floor(2^32 / M); fits 17 bits since M > 2^15
  localparam logic [16:0] Mu = 17'((64'd1 << 32) / MODULUS);

  logic [31:0] prod_r;
  logic [31:0] prod2_r;
  logic [31:0] prod3_r;
  logic [33:0] est_r;
  logic [32:0] qm_r;
  logic [15:0] res_r;
  logic [16:0] quot;
  logic [31:0] diff;
  logic [17:0] rem0;
  logic [17:0] rem1;
  logic [17:0] rem2;

  assign quot = est_r[33:17];
  assign diff = prod3_r - qm_r[31:0];
  // Barrett estimate is short by at most two
  assign rem0 = diff[17:0];
  assign rem1 = (rem0 >= {2'b00, Mod}) ? rem0 - {2'b00, Mod} : rem0;
  assign rem2 = (rem1 >= {2'b00, Mod}) ? rem1 - {2'b00, Mod} : rem1;

  always_ff @(posedge clk) begin
    prod_r  <= {16'd0, x} * {16'd0, y};
    prod2_r <= prod_r;
    est_r   <= {17'd0, prod_r[31:15]} * {17'd0, Mu};
    prod3_r <= prod2_r;
    qm_r    <= {16'd0, quot} * {17'd0, Mod};
    res_r   <= rem2[15:0];
  end

  assign res = res_r;

endmodule

// ===== sv/pfa_inv_table.sv =====
// Inverse table, filled after reset by a Wilson-theorem sweep:
// forward pass stores prefix products P(i) = i! mod M, backward pass
// starts from inv(P(M-1)) = M-1 and overwrites entry i with inv(i).
module pfa_inv_table #(
  parameter int unsigned MODULUS = pfa_pkg::MODULUS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pfa_pkg::ELEM_W-1:0]  rd_addr,
  output logic [pfa_pkg::ELEM_W-1:0]  rd_data,
  output logic                        fill_done
);

  localparam int unsigned W = pfa_pkg::ELEM_W;
  localparam logic [W-1:0] LastIdx = MODULUS[W-1:0] - 1'b1;

  // step phases
  localparam logic [2:0] PhIssue   = 3'd0;
  localparam logic [2:0] PhMulA    = 3'd1;
  localparam logic [2:0] PhFwdDone = 3'd4;
  localparam logic [2:0] PhWr      = 3'd5;
  localparam logic [2:0] PhStep    = 3'd6;

  logic [W-1:0] mem [pfa_pkg::ROM_DEPTH];

  pfa_pkg::fill_state_t state_r, state_nxt;
  logic [2:0]   phase_r, phase_nxt;
  logic [W-1:0] idx_r, idx_nxt;
  logic [W-1:0] prod_r, prod_nxt;
  logic [W-1:0] q_r, q_nxt;
  logic [W-1:0] rdata_r;
  logic         we;
  logic [W-1:0] waddr;
  logic [W-1:0] wdata;
  logic [W-1:0] raddr;
  logic [W-1:0] mx;
  logic [W-1:0] my;
  logic [W-1:0] mres;

  pfa_mulmod #(
    .MODULUS (MODULUS)
  ) u_mul (
    .clk (clk),
    .x   (mx),
    .y   (my),
    .res (mres)
  );

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    prod_nxt  = prod_r;
    q_nxt     = q_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = mres;
    raddr     = rd_addr;
    mx        = prod_r;
    my        = idx_r;
    case (state_r)
      pfa_pkg::FILL_INIT: begin
        we        = 1'b1;
        waddr     = W'(1);
        wdata     = W'(1);
        prod_nxt  = W'(1);
        idx_nxt   = W'(2);
        phase_nxt = PhIssue;
        state_nxt = pfa_pkg::FILL_FWD;
      end
      pfa_pkg::FILL_FWD: begin
        if (phase_r == PhFwdDone) begin
          we        = 1'b1;
          prod_nxt  = mres;
          phase_nxt = PhIssue;
          if (idx_r == LastIdx) begin
            q_nxt     = LastIdx;
            state_nxt = pfa_pkg::FILL_BWD;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end
      pfa_pkg::FILL_BWD: begin
        raddr = idx_r - 1'b1;
        mx    = q_r;
        my    = (phase_r == PhMulA) ? rdata_r : idx_r;
        if (phase_r == PhWr) begin
          we = 1'b1;
        end
        if (phase_r == PhStep) begin
          q_nxt     = mres;
          phase_nxt = PhIssue;
          if (idx_r == W'(2)) begin
            state_nxt = pfa_pkg::FILL_DONE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end
      pfa_pkg::FILL_DONE: begin
      end
      default: begin
        state_nxt = pfa_pkg::FILL_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::FILL_INIT;
      phase_r <= PhIssue;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rd_data   = rdata_r;
  assign fill_done = (state_r == pfa_pkg::FILL_DONE);

endmodule

// ===== sv/prime_field_alu_16bit.sv =====
// Throughput: one word per cycle, set by a fully pipelined Barrett multiplier,
// while the table is filled and the output queue has an uncommitted slot.
// Reset (rst_n low, synchronous): pipeline and output queue empty, then the
// inverse table fills itself; in_ready stays low until the fill is done.
module prime_field_alu_16bit #(
  parameter int unsigned MODULUS = pfa_pkg::MODULUS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfa_pkg::pfa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfa_pkg::pfa_out_t out_data
);

  localparam int unsigned W      = pfa_pkg::ELEM_W;
  localparam int unsigned MulLat = pfa_pkg::MUL_LAT;
  localparam int unsigned Depth  = pfa_pkg::FIFO_DEPTH;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned PtrW   = $clog2(Depth) + 1;
  localparam logic [W-1:0] Mod   = MODULUS[W-1:0];

  // Sideband carried alongside the multiplier
  typedef struct packed {
    logic         use_mul;
    logic [W-1:0] simple;
    logic         flag;
  } side_t;

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  logic             in_acc;
  logic             out_acc;
  pfa_pkg::pfa_in_t in_r;
  logic             v1_r;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
  end

  // Operands are below 2^16 < 2M, so one conditional subtract reduces them.
  logic [W-1:0] a_red;
  logic [W-1:0] b_red;
  logic [W-1:0] rom_addr;
  logic [W-1:0] rom_data;
  logic         fill_done;

  assign a_red    = (in_r.operand_a >= Mod) ? in_r.operand_a - Mod : in_r.operand_a;
  assign b_red    = (in_r.operand_b >= Mod) ? in_r.operand_b - Mod : in_r.operand_b;
  // Invert looks up a, divide looks up b
  assign rom_addr = (in_r.opcode == pfa_pkg::OP_INV) ? a_red : b_red;

  pfa_inv_table #(
    .MODULUS (MODULUS)
  ) u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rom_addr),
    .rd_data   (rom_data),
    .fill_done (fill_done)
  );

  // ---------------------------------------------------------------------
  // Stage 2: reduced operands, table word arrives with them
  // ---------------------------------------------------------------------
  logic [2:0]   op2_r;
  logic [W-1:0] a2_r;
  logic [W-1:0] b2_r;
  logic         v2_r;

  always_ff @(posedge clk) begin
    op2_r <= in_r.opcode;
    a2_r  <= a_red;
    b2_r  <= b_red;
  end

  // ---------------------------------------------------------------------
  // Stage 3: add/sub/neg/inv finish here; mul/div enter the multiplier
  // ---------------------------------------------------------------------
  logic [W:0]   sum;
  logic [W-1:0] add_res;
  logic [W-1:0] neg_b;
  logic [W:0]   dsum;
  logic [W-1:0] sub_res;
  logic [W-1:0] neg_a;
  logic         a_zero;
  logic         b_zero;
  side_t        side;
  logic [W-1:0] mul_y;
  logic [W-1:0] mul_res;

  assign a_zero  = (a2_r == '0);
  assign b_zero  = (b2_r == '0);
  assign sum     = {1'b0, a2_r} + {1'b0, b2_r};
  assign add_res = (sum >= {1'b0, Mod}) ? W'(sum - {1'b0, Mod}) : sum[W-1:0];
  // negating zero gives zero, never M
  assign neg_b   = b_zero ? '0 : Mod - b2_r;
  assign neg_a   = a_zero ? '0 : Mod - a2_r;
  assign dsum    = {1'b0, a2_r} + {1'b0, neg_b};
  assign sub_res = (dsum >= {1'b0, Mod}) ? W'(dsum - {1'b0, Mod}) : dsum[W-1:0];
  assign mul_y   = (op2_r == pfa_pkg::OP_DIV) ? rom_data : b2_r;

  always_comb begin
    side = '0;
    case (op2_r)
      pfa_pkg::OP_ADD: side.simple = add_res;
      pfa_pkg::OP_SUB: side.simple = sub_res;
      pfa_pkg::OP_MUL: side.use_mul = 1'b1;
      pfa_pkg::OP_DIV: begin
        // divide by zero: result 0, flag set
        side.flag    = b_zero;
        side.use_mul = !b_zero;
      end
      pfa_pkg::OP_NEG: side.simple = neg_a;
      pfa_pkg::OP_INV: begin
        side.flag   = a_zero;
        side.simple = a_zero ? '0 : rom_data;
      end
      default: side = '0;
    endcase
  end

  pfa_mulmod #(
    .MODULUS (MODULUS)
  ) u_mul (
    .clk (clk),
    .x   (a2_r),
    .y   (mul_y),
    .res (mul_res)
  );

  side_t            side_r [MulLat];
  logic [MulLat-1:0] vm_r;

  always_ff @(posedge clk) begin
    side_r[0] <= side;
    for (int i = 1; i < MulLat; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Output queue. Credits cover everything in flight, so the pipeline
  // never stalls and the queue never overflows.
  // ---------------------------------------------------------------------
  pfa_pkg::pfa_out_t fin;
  pfa_pkg::pfa_out_t fifo_r [Depth];
  logic [PtrW-1:0]   wptr_r;
  logic [PtrW-1:0]   rptr_r;
  logic [CntW-1:0]   cnt_r;
  logic [CntW-1:0]   cnt_nxt;
  logic              push;

  assign push            = vm_r[MulLat-1];
  assign fin.result      = side_r[MulLat-1].use_mul ? mul_res : side_r[MulLat-1].simple;
  assign fin.zero_divide = side_r[MulLat-1].flag;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r[PtrW-2:0]] <= fin;
    end
  end

  assign cnt_nxt = cnt_r + CntW'(in_acc) - CntW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      vm_r   <= '0;
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      v1_r   <= in_acc;
      v2_r   <= v1_r;
      vm_r   <= {vm_r[MulLat-2:0], v2_r};
      cnt_r  <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (out_acc) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  // Take a new word once the table is filled, whenever a queue slot is still uncommitted
  assign in_ready  = fill_done && (cnt_r != CntW'(Depth));
  assign out_valid = (wptr_r != rptr_r);
  assign out_data  = fifo_r[rptr_r[PtrW-2:0]];

endmodule

// ===== tb/pfa_result_checker.sv =====
module pfa_result_checker #(
  parameter int unsigned MODULUS = pfa_pkg::MODULUS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  pfa_pkg::pfa_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  pfa_pkg::pfa_out_t out_data,
  output int                errors,
  output int                pending
);

  // expected words, kept in order of acceptance
  localparam int QDepth = 4096;

  pfa_pkg::pfa_out_t expected_results [QDepth];
  int wr_cnt = 0;
  int rd_cnt = 0;

  function automatic int unsigned field_neg(int unsigned x);
    return (x == 0) ? 0 : MODULUS - x;
  endfunction

  function automatic int unsigned field_mul(int unsigned x, int unsigned y);
    longint unsigned prod;
    prod = longint'(x) * longint'(y);
    return int'(prod % MODULUS);
  endfunction

  // x^(p-2) mod p; x is already reduced and nonzero
  function automatic int unsigned field_inverse(int unsigned x);
    int unsigned acc;
    int unsigned base;
    int unsigned e;
    acc  = 1;
    base = x;
    e    = MODULUS - 2;
    while (e != 0) begin
      if (e[0]) acc = field_mul(acc, base);
      base = field_mul(base, base);
      e    = e >> 1;
    end
    return acc;
  endfunction

  function automatic pfa_pkg::pfa_out_t compute_field_op(pfa_pkg::pfa_in_t w);
    pfa_pkg::pfa_out_t r;
    int unsigned       a;
    int unsigned       b;
    a = w.operand_a % MODULUS;
    b = w.operand_b % MODULUS;
    r = '0;
    case (w.opcode)
      pfa_pkg::OP_ADD: r.result = 16'((a + b) % MODULUS);
      pfa_pkg::OP_SUB: r.result = 16'((a + field_neg(b)) % MODULUS);
      pfa_pkg::OP_MUL: r.result = 16'(field_mul(a, b));
      pfa_pkg::OP_DIV: begin
        if (b == 0) r.zero_divide = 1'b1;
        else r.result = 16'(field_mul(a, field_inverse(b)));
      end
      pfa_pkg::OP_NEG: r.result = 16'(field_neg(a));
      pfa_pkg::OP_INV: begin
        if (a == 0) r.zero_divide = 1'b1;
        else r.result = 16'(field_inverse(a));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pfa_pkg::pfa_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected word result=%0d zero_divide=%0b",
                   $time, out_data.result, out_data.zero_divide);
          errors++;
        end else begin
          want = expected_results[rd_cnt % QDepth];
          rd_cnt++;
          if (out_data.result !== want.result) begin
            $display("%0t: result mismatch expected=%0d actual=%0d",
                     $time, want.result, out_data.result);
            errors++;
          end
          if (out_data.zero_divide !== want.zero_divide) begin
            $display("%0t: zero_divide mismatch expected=%0b actual=%0b",
                     $time, want.zero_divide, out_data.zero_divide);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results[wr_cnt % QDepth] = compute_field_op(in_data);
        wr_cnt++;
      end
      pending = wr_cnt - rd_cnt;
    end
  end

endmodule

// ===== tb/tb_prime_field_alu_16bit.sv =====
module tb_prime_field_alu_16bit;

  localparam int unsigned P = pfa_pkg::MODULUS_DEFAULT;

  // opcodes the block leaves unused; they must give 0 with no flag
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // Longest legit quiet stretch is the inverse-table fill after reset;
  // allow several times that.
  localparam int STALL_LIMIT = 3_000_000;

  localparam int RANDOM_BLOCKS = 20;
  localparam int BLOCK_WORDS   = 100;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  pfa_pkg::pfa_in_t  in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pfa_pkg::pfa_out_t out_data;

  int errors;
  int pending;
  int idle_cycles = 0;

  // calm = no idling on either side for the current block
  bit calm;
  int ready_hold = 0;

  prime_field_alu_16bit #(.MODULUS(P)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  pfa_result_checker #(.MODULUS(P)) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length before a word: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Operand mix: boundary values around the prime, values that reduce to
  // small residues (including zero), small values and plain random ones.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return 16'd0;
          1: return 16'd1;
          2: return 16'd2;
          3: return 16'(P - 1);
          4: return 16'(P);
          5: return 16'(P + 1);
          default: return 16'hFFFF;
        endcase
      end
      1: return 16'($urandom_range(P, 65535));
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pfa_pkg::pfa_in_t rand_word();
    pfa_pkg::pfa_in_t w;
    if ($urandom_range(0, 19) < 18) w.opcode = 3'($urandom_range(0, 5));
    else w.opcode = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
    w.operand_a = pick_operand();
    w.operand_b = pick_operand();
    return w;
  endfunction

  function automatic pfa_pkg::pfa_in_t mk(logic [2:0] op, logic [15:0] a, logic [15:0] b);
    pfa_pkg::pfa_in_t w;
    w.opcode    = op;
    w.operand_a = a;
    w.operand_b = b;
    return w;
  endfunction

  // Present one word and return at the edge that accepts it. Ready is
  // sampled at the falling edge, where every input is settled.
  task automatic send_word(pfa_pkg::pfa_in_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Result-side back-pressure: runs of ready high or low, mostly short.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 20);
    end else begin
      out_ready  <= ($urandom_range(0, 3) != 0);
      ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 3);
    end
  end

  // Watchdog: cycles in a row with nothing accepted on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: field extremes, every opcode, zero divisor and
    // zero inversion (direct and via a value that reduces to zero),
    // negate of zero, subtract of zero, and the unused opcodes.
    // The first word waits out the table fill via in_ready.
    send_word(mk(pfa_pkg::OP_ADD, 16'd0, 16'd0));
    send_word(mk(pfa_pkg::OP_ADD, 16'(P - 1), 16'(P - 1)));
    send_word(mk(pfa_pkg::OP_ADD, 16'hFFFF, 16'hFFFF));
    send_word(mk(pfa_pkg::OP_SUB, 16'd0, 16'd0));
    send_word(mk(pfa_pkg::OP_SUB, 16'd5, 16'd0));
    send_word(mk(pfa_pkg::OP_SUB, 16'd0, 16'd1));
    send_word(mk(pfa_pkg::OP_SUB, 16'hFFFF, 16'(P)));
    send_word(mk(pfa_pkg::OP_MUL, 16'hFFFF, 16'hFFFF));
    send_word(mk(pfa_pkg::OP_MUL, 16'(P - 1), 16'(P - 1)));
    send_word(mk(pfa_pkg::OP_DIV, 16'd1234, 16'd0));
    send_word(mk(pfa_pkg::OP_DIV, 16'hFFFF, 16'(P)));
    send_word(mk(pfa_pkg::OP_DIV, 16'd0, 16'd5));
    send_word(mk(pfa_pkg::OP_DIV, 16'd1, 16'(P - 1)));
    send_word(mk(pfa_pkg::OP_NEG, 16'd0, 16'hFFFF));
    send_word(mk(pfa_pkg::OP_NEG, 16'(P), 16'd0));
    send_word(mk(pfa_pkg::OP_NEG, 16'd1, 16'd0));
    send_word(mk(pfa_pkg::OP_NEG, 16'hFFFF, 16'd0));
    send_word(mk(pfa_pkg::OP_INV, 16'd0, 16'd7));
    send_word(mk(pfa_pkg::OP_INV, 16'(P), 16'd0));
    send_word(mk(pfa_pkg::OP_INV, 16'd1, 16'd0));
    send_word(mk(pfa_pkg::OP_INV, 16'd2, 16'd0));
    send_word(mk(pfa_pkg::OP_INV, 16'(P - 1), 16'd0));
    send_word(mk(pfa_pkg::OP_INV, 16'hFFFF, 16'd0));
    send_word(mk(OP_RSVD6, 16'hFFFF, 16'hFFFF));
    send_word(mk(OP_RSVD7, 16'd3, 16'd0));

    // Random part in blocks; some blocks run with no idling at all.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCK_WORDS; n++) send_word(rand_word());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then a tail well past the pipeline depth to catch strays.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== prime_field_alu_16bit.f =====
sv/pfa_pkg.sv
sv/pfa_mulmod.sv
sv/pfa_inv_table.sv
sv/prime_field_alu_16bit.sv
tb/pfa_result_checker.sv
tb/tb_prime_field_alu_16bit.sv
